FILE: rtl/tcg_pkg.sv
// Shared types, constants and the breathing-curve shape function for the
// timed curve generator. No dependencies; every file but the two interfaces imports it.
package tcg_pkg;

    // Default sizes handed to the top-level parameters
    localparam int ROM_ENTRIES_DEF = 256;
    localparam int TIME_WIDTH_DEF  = 32;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] HALF_Q16    = 17'd32768;
    localparam int          QUOT_BITS   = 17;
    localparam logic [31:0] TRIGGER_MIN = 32'd7;
    localparam logic [31:0] PERIOD_RST  = 32'd1000;
    localparam logic [63:0] ONE_Q31     = 64'h0000_0000_8000_0000;

    typedef enum logic [1:0] {
        CURVE_TOGGLE = 2'd0,
        CURVE_LINEAR = 2'd1,
        CURVE_EXP    = 2'd2,
        CURVE_BREATH = 2'd3
    } t_curve_mode;

    typedef enum logic [1:0] {
        CFG_CURVE_MODE = 2'd0,
        CFG_REPEAT     = 2'd1,
        CFG_PERIOD     = 2'd2
    } t_cfg_index;

    // Command from the sequencer to the serial accumulator
    typedef struct packed {
        logic start;
        logic clear;
    } t_acc_cmd;

    // exp(-y) from y in Q31: series on y/256, then square eight times.
    // Evaluated at elaboration only, to fill the breathing table.
    function automatic logic [16:0] breath_shape(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] e;
        z  = y >> 8;
        z2 = (z * z) >> 31;
        z3 = (z2 * z) >> 31;
        e  = ONE_Q31 - z + z2 / 2 - z3 / 6;
        for (int k = 0; k < 8; k++) begin
            e = (e * e) >> 31;
        end
        e = (e + 64'd16384) >> 15;
        if (e > 64'd65536) begin
            e = 64'd65536;
        end
        return e[16:0];
    endfunction

endpackage

FILE: rtl/tcg_in_if.sv
// Tick channel of the timed curve generator: valid/ready plus tick payload.
// Depends on nothing.
interface tcg_in_if;
    logic               valid;
    logic               ready;
    logic               trigger_connected;
    logic signed [31:0] trigger_value;
    logic        [15:0] time_step;

    modport source (output valid, trigger_connected, trigger_value, time_step,
                    input ready);
    modport sink   (input valid, trigger_connected, trigger_value, time_step,
                    output ready);
endinterface

FILE: rtl/tcg_out_if.sv
// Level channel of the timed curve generator: valid/ready plus Q1.16 level.
// Depends on nothing.
interface tcg_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] level;

    modport source (output valid, level, input ready);
    modport sink   (input valid, level, output ready);
endinterface

FILE: rtl/timed_curve_generator_top.sv
// Timed curve generator top: configuration registers, tick sequencer and
// output register. Uses tcg_pkg, tcg_in_if, tcg_out_if and the tcg_* units.
//
//  channel   | dir | transaction
//  ----------+-----+---------------------------------------------------
//  i_tick    | in  | trigger_connected, trigger_value Q16.16, time_step
//  o_result  | out | level, unsigned Q1.16
//  i_cfg_*   | in  | register write: index, data (no read-back)
//
// An active tick goes from acceptance to the output register through the
// bit-serial add/compare over max(TIME_WIDTH,32) bits plus its resolve, 17
// divider steps, then multiply, table read and select. A zero period skips
// the divider steps. A disconnected or inactive tick goes from acceptance
// to S_DONE and from there to the output register. One tick is in work at
// a time; the next is taken while a finished level waits in the output
// register.
// Reset is synchronous, active low; the sequencer holds a result until the
// output register is free.
module timed_curve_generator_top
    import tcg_pkg::*;
#(
    parameter int CURVE_ROM_ENTRIES = ROM_ENTRIES_DEF,
    parameter int TIME_WIDTH        = TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcg_in_if.sink     i_tick,
    tcg_out_if.source  o_result,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_SHAPE,
        S_DONE
    } t_state;

    t_state      r_state;
    t_curve_mode r_mode;
    logic        r_repeat;
    logic [31:0] r_period;
    logic        r_zero;
    logic        r_out_valid;
    logic [16:0] r_out_level;

    t_acc_cmd              acc_cmd;
    logic                  acc_done;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  div_start;
    logic                  div_done;
    logic [16:0]           prog;
    logic                  shp_start;
    logic                  shp_done;
    logic [16:0]           shp_level;
    logic                  tick_acc;
    logic                  trig_active;
    logic                  out_free;
    logic                  out_load;

    // Write configuration registers; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= CURVE_LINEAR;
            r_repeat <= 1'b0;
            r_period <= PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CURVE_MODE: r_mode   <= t_curve_mode'(i_cfg_data[1:0]);
                CFG_REPEAT:     r_repeat <= i_cfg_data[0];
                CFG_PERIOD:     r_period <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        tick_acc      = i_tick.valid && (r_state == S_IDLE);
        trig_active   = (i_tick.trigger_value >= $signed(TRIGGER_MIN));
        out_free      = !r_out_valid || o_result.ready;
        out_load      = (r_state == S_DONE) && out_free;
        acc_cmd.start = tick_acc && i_tick.trigger_connected && trig_active;
        acc_cmd.clear = tick_acc && i_tick.trigger_connected && !trig_active;
        div_start     = (r_state == S_ACC) && acc_done;
        shp_start     = (r_state == S_DIV) && div_done;
    end

    // Sequence one tick and hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_zero      <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_level <= r_zero ? '0 : shp_level;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tick_acc) begin
                        r_zero  <= !(i_tick.trigger_connected && trig_active);
                        r_state <= acc_cmd.start ? S_ACC : S_DONE;
                    end
                end
                S_ACC: begin
                    if (acc_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SHAPE;
                    end
                end
                S_SHAPE: begin
                    if (shp_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_tick.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.level = r_out_level;

    tcg_accum #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (acc_cmd),
        .i_step    (i_tick.time_step),
        .i_period  (r_period),
        .i_repeat  (r_repeat),
        .o_elapsed (elapsed),
        .o_done    (acc_done)
    );

    tcg_divider #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_elapsed (elapsed),
        .i_period  (r_period),
        .o_quot    (prog),
        .o_done    (div_done)
    );

    tcg_shaper #(
        .CURVE_ROM_ENTRIES (CURVE_ROM_ENTRIES)
    ) u_shaper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (shp_start),
        .i_mode  (r_mode),
        .i_prog  (prog),
        .o_level (shp_level),
        .o_done  (shp_done)
    );

    // Unit completions arrive only in the state that waits for them
    a_acc_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_done |-> (r_state == S_ACC))
        else $error("accumulator finished outside its state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its state");

    a_shp_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shp_done |-> (r_state == S_SHAPE))
        else $error("shaper finished outside its state");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished tick did not reach the output register");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_level <= ONE_Q16))
        else $error("output level above 1.0");

endmodule

FILE: rtl/tcg_accum.sv
// Bit-serial elapsed-time accumulator: adds the step LSB first, compares
// against the period on the fly, then applies saturate/wrap/clamp. Uses tcg_pkg.
module tcg_accum
    import tcg_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_acc_cmd              i_cmd,
    input  logic [15:0]           i_step,
    input  logic [31:0]           i_period,
    input  logic                  i_repeat,
    output logic [TIME_WIDTH-1:0] o_elapsed,
    output logic                  o_done
);

    // Serial length covers both the counter and the 32-bit period
    localparam int SW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int CW = $clog2(SW);

    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [15:0]           r_step;
    logic [31:0]           r_per;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_fix;
    logic                  r_done;
    logic                  r_carry;
    logic                  r_gt_raw;
    logic                  r_gt_max;
    logic                  r_ovf;

    logic                  in_tw;
    logic                  e_bit;
    logic                  s_bit;
    logic                  p_bit;
    logic                  sum_bit;
    logic                  n_carry;
    logic                  n_gt_raw;
    logic                  n_gt_max;
    logic                  ovf_all;
    logic                  gt_fin;
    logic [TIME_WIDTH-1:0] per_tw;
    logic [TIME_WIDTH-1:0] n_fixed;

    // One bit of sum and of both compares per cycle
    always_comb begin
        in_tw    = ({1'b0, r_cnt} < (CW + 1)'(TIME_WIDTH));
        e_bit    = in_tw & r_elapsed[0];
        s_bit    = r_step[0];
        p_bit    = r_per[0];
        sum_bit  = e_bit ^ s_bit ^ r_carry;
        n_carry  = (e_bit & s_bit) | (e_bit & r_carry) | (s_bit & r_carry);
        n_gt_raw = (sum_bit & ~p_bit) | (~(sum_bit ^ p_bit) & r_gt_raw);
        n_gt_max = (in_tw & ~p_bit) | (~(in_tw ^ p_bit) & r_gt_max);
    end

    // Resolve the stored value once the serial pass is over
    always_comb begin
        ovf_all = r_ovf | r_carry;
        gt_fin  = ovf_all ? r_gt_max : r_gt_raw;
        per_tw  = TIME_WIDTH'(i_period);
        if (gt_fin) begin
            n_fixed = i_repeat ? '0 : per_tw;
        end else if (ovf_all) begin
            n_fixed = '1;
        end else begin
            n_fixed = r_elapsed;
        end
    end

    // Hold sequencing and the elapsed counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_fix     <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
            r_elapsed <= '0;
        end else begin
            r_done <= r_fix;
            r_fix  <= r_busy && !i_cmd.start && (r_cnt == CW'(SW - 1));
            if (i_cmd.clear) begin
                r_elapsed <= '0;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (in_tw) begin
                    r_elapsed <= {sum_bit, r_elapsed[TIME_WIDTH-1:1]};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SW - 1)) begin
                    r_busy <= 1'b0;
                end
            end else if (r_fix) begin
                r_elapsed <= n_fixed;
            end
        end
    end

    // Advance the operand shift registers and the serial flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_step   <= i_step;
            r_per    <= i_period;
            r_carry  <= 1'b0;
            r_gt_raw <= 1'b0;
            r_gt_max <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (r_busy) begin
            r_step   <= {1'b0, r_step[15:1]};
            r_per    <= {1'b0, r_per[31:1]};
            r_carry  <= n_carry;
            r_gt_raw <= n_gt_raw;
            r_gt_max <= n_gt_max;
            r_ovf    <= r_ovf | (~in_tw & sum_bit);
        end
    end

    assign o_elapsed = r_elapsed;
    assign o_done    = r_done;

endmodule

FILE: rtl/tcg_divider.sv
// Radix-2 restoring divider: progress = elapsed * 2^16 / period, one quotient
// bit per cycle shifted into the quotient register. Uses tcg_pkg.
module tcg_divider
    import tcg_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_elapsed,
    input  logic [31:0]           i_period,
    output logic [16:0]           o_quot,
    output logic                  o_done
);

    localparam int QCW = $clog2(QUOT_BITS);

    logic [32:0]    r_rem;
    logic [16:0]    r_quot;
    logic [QCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [32:0]    trial;
    logic           ge;
    logic           last_step;

    // First step compares the dividend itself, later steps the doubled rest
    always_comb begin
        trial     = (r_cnt == '0) ? r_rem : {r_rem[31:0], 1'b0};
        ge        = (trial >= {1'b0, i_period});
        last_step = r_busy && (r_cnt == QCW'(QUOT_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= i_start ? (i_period == '0) : last_step;
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= (i_period != '0);
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Elapsed never exceeds the period after an update, so 32 bits carry it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, 32'(i_elapsed)};
            r_quot <= (i_period == '0) ? ONE_Q16 : '0;
        end else if (r_busy) begin
            r_rem  <= ge ? (trial - {1'b0, i_period}) : trial;
            r_quot <= {r_quot[15:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

FILE: rtl/tcg_shaper.sv
// Curve shaping: one shared multiplier, breathing table lookup and mode
// select, as a three-stage pipeline. Uses tcg_pkg (breath_shape, modes).
module tcg_shaper
    import tcg_pkg::*;
#(
    parameter int CURVE_ROM_ENTRIES = ROM_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_curve_mode i_mode,
    input  logic [16:0] i_prog,
    output logic [16:0] o_level,
    output logic        o_done
);

    localparam int          LAST  = (CURVE_ROM_ENTRIES > 1) ? CURVE_ROM_ENTRIES - 1 : 1;
    localparam int          IW    = $clog2(CURVE_ROM_ENTRIES);
    localparam logic [63:0] Den   = 64'(8) * 64'(LAST) * 64'(LAST);
    localparam logic [16:0] LastQ = 17'(LAST);

    logic [16:0] rom [CURVE_ROM_ENTRIES];

    // Fill the breathing table at elaboration
    for (genvar gi = 0; gi < CURVE_ROM_ENTRIES; gi++) begin : g_rom
        localparam longint      Num = 10 * longint'(gi) - 5 * longint'(LAST);
        localparam logic [63:0] Mag = (Num < 0) ? 64'(-Num) : 64'(Num);
        localparam logic [63:0] Y   = ((Mag * Mag) << 31) / Den;
        assign rom[gi] = breath_shape(Y);
    end

    logic [33:0]   r_prod;
    logic [16:0]   r_rom;
    logic [16:0]   r_level;
    logic [2:0]    r_vld;

    logic [16:0]   mul_b;
    logic [34:0]   idx_sum;
    logic [IW-1:0] rom_idx;
    logic [16:0]   n_level;

    always_comb begin
        mul_b   = (i_mode == CURVE_BREATH) ? LastQ : i_prog;
        idx_sum = {1'b0, r_prod} + 35'(HALF_Q16);
        rom_idx = idx_sum[16 +: IW];
    end

    // Select the curve from the progress, the registered product or the table word
    always_comb begin
        unique case (i_mode)
            CURVE_TOGGLE: n_level = (i_prog > HALF_Q16) ? ONE_Q16 : '0;
            CURVE_LINEAR: n_level = i_prog;
            CURVE_EXP:    n_level = r_prod[32:16];
            CURVE_BREATH: n_level = r_rom;
            default:      n_level = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= i_prog * mul_b;
        end
        if (r_vld[0]) begin
            r_rom <= rom[rom_idx];
        end
        if (r_vld[1]) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;
    assign o_done  = r_vld[2];

endmodule

FILE: tb/tcg_checker.sv
// Scoreboard for the timed curve generator: mirrors the register writes,
// predicts one level per accepted tick and compares the levels that come out.
// Depends on tcg_pkg, tcg_in_if and tcg_out_if.
module tcg_checker
    import tcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcg_in_if           i_tick,
    tcg_out_if          i_result,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int          ROM_SIZE   = ROM_ENTRIES_DEF;
    localparam logic [63:0] ROM_LAST   = 64'(ROM_ENTRIES_DEF - 1);
    localparam logic [63:0] TIME_LIMIT = 64'hFFFF_FFFF;
    localparam logic [63:0] HALF_STEP  = 64'd32768;

    // Mirrored registers and the time counter
    t_curve_mode mode_q;
    logic        repeat_q;
    logic [31:0] period_q;
    logic [31:0] elapsed_q;

    logic [16:0] breath_table [ROM_SIZE];
    logic [16:0] pending_levels [$];
    int          fail_count;

    // exp(-d*d/2) for table slot idx, d = 5 * (idx/last - 0.5), Q1.16
    function automatic logic [16:0] gauss_level(int idx);
        longint      num;
        logic [63:0] mag;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] e;
        num = 10 * longint'(idx) - 5 * longint'(ROM_LAST);
        mag = (num < 0) ? 64'(-num) : 64'(num);
        y   = ((mag * mag) << 31) / (64'd8 * ROM_LAST * ROM_LAST);
        z   = y >> 8;
        z2  = (z * z) >> 31;
        z3  = (z2 * z) >> 31;
        e   = ONE_Q31 - z + z2 / 2 - z3 / 6;
        repeat (8) e = (e * e) >> 31;
        e = (e + 64'd16384) >> 15;
        if (e > 64'd65536) begin
            e = 64'd65536;
        end
        return e[16:0];
    endfunction

    // Advance the counter for one tick and shape its progress into a level
    function automatic logic [16:0] advance_and_shape(logic conn, logic [31:0] trig,
                                                      logic [15:0] step);
        logic [63:0] sum;
        logic [63:0] prog;
        logic [63:0] sq;
        logic [63:0] slot;
        if (!conn) begin
            return 17'd0;
        end
        if (trig[31] || trig < TRIGGER_MIN) begin
            elapsed_q = '0;
            return 17'd0;
        end
        sum = {32'd0, elapsed_q} + {48'd0, step};
        if (sum > TIME_LIMIT) begin
            sum = TIME_LIMIT;
        end
        if (sum > {32'd0, period_q}) begin
            sum = repeat_q ? 64'd0 : {32'd0, period_q};
        end
        elapsed_q = sum[31:0];
        if (period_q == '0) begin
            prog = 64'd65536;
        end else begin
            prog = {16'd0, elapsed_q, 16'd0} / {32'd0, period_q};
        end
        if (prog > 64'd65536) begin
            prog = 64'd65536;
        end
        case (mode_q)
            CURVE_TOGGLE: return (prog > HALF_STEP) ? ONE_Q16 : 17'd0;
            CURVE_LINEAR: return prog[16:0];
            CURVE_EXP: begin
                sq = (prog * prog) >> 16;
                return sq[16:0];
            end
            default: begin
                slot = (prog * ROM_LAST + HALF_STEP) >> 16;
                if (slot > ROM_LAST) begin
                    slot = ROM_LAST;
                end
                return breath_table[int'(slot)];
            end
        endcase
    endfunction

    // Fill the breathing table once
    initial begin
        for (int i = 0; i < ROM_SIZE; i++) begin
            breath_table[i] = gauss_level(i);
        end
        fail_count = 0;
    end

    // Track writes, compare finished levels, then queue the new prediction
    always @(posedge i_clk) begin
        logic [16:0] want;
        if (!i_rst_n) begin
            mode_q    = CURVE_LINEAR;
            repeat_q  = 1'b0;
            period_q  = PERIOD_RST;
            elapsed_q = '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CURVE_MODE: mode_q   = t_curve_mode'(i_cfg_data[1:0]);
                    CFG_REPEAT:     repeat_q = i_cfg_data[0];
                    CFG_PERIOD:     period_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (pending_levels.size() == 0) begin
                    $error("level: no transaction expected, actual %0d", i_result.level);
                    fail_count++;
                end else begin
                    want = pending_levels.pop_front();
                    if (i_result.level !== want) begin
                        $error("level mismatch: expected %0d, actual %0d",
                               want, i_result.level);
                        fail_count++;
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                pending_levels.push_back(advance_and_shape(i_tick.trigger_connected,
                                                           i_tick.trigger_value,
                                                           i_tick.time_step));
            end
        end
        o_pending    <= pending_levels.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: tb/tb_timed_curve_generator_top.sv
// Testbench top for the timed curve generator: clock, reset, tick and
// register stimulus, bursty sender, stalling receiver, watchdog and verdict.
// Depends on tcg_pkg, tcg_in_if, tcg_out_if, tcg_checker and the RTL top.
module tb_timed_curve_generator_top;
    import tcg_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int          PHASES         = 10;
    localparam int          PHASE_TICKS    = 128;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;
    localparam logic [31:0] PERIOD_MAX     = 32'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          chk_pending;
    int          chk_failures;

    int burst_left;
    bit steady_sender;

    tcg_in_if  tick_ch ();
    tcg_out_if level_ch ();

    timed_curve_generator_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_ch),
        .o_result   (level_ch),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    tcg_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick_ch),
        .i_result    (level_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (chk_pending),
        .o_fail_count(chk_failures)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one tick, idle between bursts, return at the negedge after acceptance
    task automatic send_tick(input logic conn, input logic [31:0] trig,
                             input logic [15:0] step);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (steady_sender) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 60);
            end else begin
                gap = $urandom_range(0, 6);
            end
            if (gap != 0) begin
                tick_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        tick_ch.valid             = 1'b1;
        tick_ch.trigger_connected = conn;
        tick_ch.trigger_value     = trig;
        tick_ch.time_step         = step;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted level has come out
    task automatic wait_idle();
        tick_ch.valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    // Program all three registers; spare data bits get random values
    task automatic set_config(input t_curve_mode mode, input logic rep,
                              input logic [31:0] per);
        logic [31:0] data;
        wait_idle();
        data      = $urandom();
        data[1:0] = mode;
        write_reg(CFG_CURVE_MODE, data);
        data    = $urandom();
        data[0] = rep;
        write_reg(CFG_REPEAT, data);
        write_reg(CFG_PERIOD, per);
    endtask

    // Step size scaled to the period, with zero and full-width steps mixed in
    function automatic logic [15:0] pick_step(logic [31:0] per);
        case ($urandom_range(0, 7))
            0: return 16'($urandom());
            1: return 16'd0;
            default: begin
                if (per <= 32'd4000) begin
                    return 16'($urandom_range(0, per / 4 + 1));
                end
                return 16'($urandom_range(0, 16'hFFFF));
            end
        endcase
    endfunction

    // Mostly active levels; some inactive, negative and arbitrary words
    function automatic logic [31:0] pick_trigger();
        logic [31:0] v;
        case ($urandom_range(0, 15))
            0: return 32'($urandom_range(0, 6));
            1: return $urandom() | 32'h8000_0000;
            2: return $urandom();
            default: begin
                v = $urandom() & 32'h7FFF_FFFF;
                if (v < TRIGGER_MIN) begin
                    v = TRIGGER_MIN;
                end
                return v;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 6))
            0: return 32'($urandom_range(1, 40));
            1, 2: return 32'($urandom_range(100, 5000));
            3, 4: return 32'($urandom_range(65536, 4194304));
            5: return $urandom();
            default: begin
                case ($urandom_range(0, 2))
                    0: return 32'd1;
                    1: return PERIOD_MAX;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    // Receiver: switch between free flow, random, sparse and long stalls
    initial begin
        int stall_mode;
        int mode_left;
        int hold_left;
        stall_mode     = 0;
        mode_left      = 0;
        hold_left      = 0;
        level_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 400);
            end
            mode_left--;
            case (stall_mode)
                0: level_ch.ready = 1'b1;
                1: level_ch.ready = 1'($urandom_range(0, 1));
                2: level_ch.ready = ($urandom_range(0, 9) != 0);
                default: begin
                    if (hold_left == 0) begin
                        level_ch.ready = !level_ch.ready;
                        hold_left = level_ch.ready ? $urandom_range(1, 4)
                                                   : $urandom_range(1, 70);
                    end else begin
                        hold_left--;
                    end
                end
            endcase
        end
    end

    // Watchdog: end the run if no transaction or write happens for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((tick_ch.valid && tick_ch.ready) || (level_ch.valid && level_ch.ready)
                || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence: reset, directed ticks, random phases, drain, verdict
    initial begin
        logic        conn;
        logic [31:0] per;
        t_curve_mode mode;
        i_rst_n                   = 1'b0;
        cfg_wr_en                 = 1'b0;
        cfg_index                 = CFG_CURVE_MODE;
        cfg_data                  = '0;
        tick_ch.valid             = 1'b0;
        tick_ch.trigger_connected = 1'b0;
        tick_ch.trigger_value     = '0;
        tick_ch.time_step         = '0;
        burst_left                = 0;
        steady_sender             = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: disconnected, active, threshold edges, negative, clamp
        send_tick(1'b0, 32'h0001_0000, 16'd100);
        send_tick(1'b1, 32'h0001_0000, 16'd100);
        send_tick(1'b1, TRIGGER_MIN, 16'd0);
        send_tick(1'b1, TRIGGER_MIN - 32'd1, 16'd5);
        send_tick(1'b1, 32'h8000_0000, 16'hFFFF);
        send_tick(1'b1, 32'h7FFF_FFFF, 16'hFFFF);
        send_tick(1'b0, 32'hFFFF_FFFF, 16'hFFFF);

        // Shortest period with wrap: zero step, exact hit, overshoot
        set_config(CURVE_TOGGLE, 1'b1, 32'd1);
        send_tick(1'b1, 32'h0000_1000, 16'd0);
        send_tick(1'b1, 32'h0000_1000, 16'd1);
        send_tick(1'b1, 32'h0000_1000, 16'd2);

        // Zero period reads as full progress
        set_config(CURVE_EXP, 1'b0, 32'd0);
        send_tick(1'b1, 32'h0000_0100, 16'd5);
        send_tick(1'b1, 32'd3, 16'd5);

        // Widest period, then a write to an unused index that must be ignored
        set_config(CURVE_BREATH, 1'b0, PERIOD_MAX);
        write_reg(CFG_UNUSED, $urandom());
        send_tick(1'b1, 32'h0000_0007, 16'hFFFF);
        send_tick(1'b1, 32'h0000_0007, 16'd0);

        // Breathing across one short period from a cleared counter, ending clamped
        set_config(CURVE_BREATH, 1'b0, 32'd100);
        send_tick(1'b1, 32'd0, 16'd0);
        send_tick(1'b1, 32'h0002_0000, 16'd50);
        send_tick(1'b1, 32'h0002_0000, 16'd25);
        send_tick(1'b1, 32'h0002_0000, 16'd25);
        send_tick(1'b1, 32'h0002_0000, 16'd1);

        // Toggle exactly at one half stays low, just past it goes high
        set_config(CURVE_TOGGLE, 1'b0, 32'd2);
        send_tick(1'b1, 32'd0, 16'd0);
        send_tick(1'b1, 32'h0000_0010, 16'd1);
        send_tick(1'b1, 32'h0000_0010, 16'd1);

        // Random phases, each with its own settings
        for (int ph = 0; ph < PHASES; ph++) begin
            mode = (ph < 4) ? t_curve_mode'(2'(ph)) : t_curve_mode'(2'($urandom_range(0, 3)));
            per  = pick_period();
            set_config(mode, 1'($urandom_range(0, 1)), per);
            steady_sender = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == 3 && n == PHASE_TICKS / 2) begin
                    wait_idle();
                end
                conn = ($urandom_range(0, 19) != 0);
                send_tick(conn, pick_trigger(), pick_step(per));
            end
        end

        // Drain, then give the block time to show any stray level
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (chk_failures == 0 && chk_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tcg_pkg.sv
rtl/tcg_in_if.sv
rtl/tcg_out_if.sv
rtl/tcg_accum.sv
rtl/tcg_divider.sv
rtl/tcg_shaper.sv
rtl/timed_curve_generator_top.sv
tb/tcg_checker.sv
tb/tb_timed_curve_generator_top.sv
